[hw/rtl/lcdw_pkg.sv]
// Shared types and constants for the character LCD nibble bus writer.
package lcdw_pkg;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_CMD  = 2'd1,
    OP_HOME = 2'd2
  } op_t;

  localparam logic [1:0] REG_BACKLIGHT = 2'd0;
  localparam logic [1:0] REG_ENABLE    = 2'd1;
  localparam logic [1:0] REG_SELECT    = 2'd2;

  localparam logic [7:0] BACKLIGHT_RESET = 8'd8;
  localparam logic [7:0] ENABLE_RESET    = 8'd4;
  localparam logic [7:0] SELECT_RESET    = 8'd1;

  localparam logic [7:0] NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] CHAR_NUL    = 8'd0;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;

  // set-DDRAM-address command for the start of each row
  localparam logic [7:0] ROW_ADDR [4] = '{8'd128, 8'd192, 8'd148, 8'd212};

  // six bus bytes per LCD byte: three for the high nibble, three for the low
  localparam logic [2:0] STEP_LOW  = 3'd3;
  localparam logic [2:0] STEP_LAST = 3'd5;

  // one LCD byte waiting for the back end
  typedef struct packed {
    logic [7:0] data;
    logic       sel;   // OR in the select pattern (character data)
    logic       last;  // final LCD byte of its item
  } lcdw_entry_t;

endpackage

[hw/rtl/char_lcd_nibble_bus_writer_core.sv]
// Top level of the character LCD nibble bus writer.
//
// Usage:
//   s_* channel takes one item per handshake: op in s_tdata[1:0]
//   (character, raw command, home), value in s_tdata[9:2].
//   m_* channel gives the expander bus bytes, one per handshake; m_tlast
//   marks the final bus byte of an item.
//   cfg_* channel writes backlight, enable and select masks (index 0..2);
//   cfg_ready is always high, write only while the block is idle.
// Throughput: the back end emits one bus byte per cycle while m_tready is high, so an item
//   gives six bus bytes (twelve for a character that wraps the row); the front end and
//   queue accept a new item while earlier bytes are still being emitted.
//   Characters NUL, CR, LF and the unused op give no output.
// Path: an accepted item passes the queue entry, the back-end byte register and the
//   output register before its first bus byte shows on m_tdata.
// Reset: synchronous; clears cursor, queue and output valid, masks go to
//   their defaults (backlight 8, enable 4, select 1).
// Stall: when m_tready is low the output register holds; the queue fills
//   and then s_tready drops. After a row wrap s_tready is also low while the next row's
//   address command is queued.
module char_lcd_nibble_bus_writer_core #(
  parameter int ROWS        = 4,
  parameter int COLUMNS     = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [1:0] op, [9:2] value, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] bus_byte
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lcdw_pkg::*;

  logic [7:0]  backlight_mask;
  logic [7:0]  enable_mask;
  logic [7:0]  select_mask;

  logic        push;
  lcdw_entry_t push_entry;
  logic        full;
  logic        pop;
  logic        head_valid;
  lcdw_entry_t head;

  assign cfg_ready = 1'b1;

  // mask registers
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_mask <= BACKLIGHT_RESET;
      enable_mask    <= ENABLE_RESET;
      select_mask    <= SELECT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BACKLIGHT: backlight_mask <= cfg_data;
        REG_ENABLE:    enable_mask    <= cfg_data;
        REG_SELECT:    select_mask    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // classify items, move the cursor
  lcdw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // decouples front and back
  lcdw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // nibble split and enable strobe
  lcdw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .backlight_mask (backlight_mask),
    .enable_mask    (enable_mask),
    .select_mask    (select_mask),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule

[hw/rtl/lcdw_front.sv]
// Front end: accepts items, tracks the cursor, queues LCD bytes.
module lcdw_front #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // [1:0] op, [9:2] value, [15:10] zero
  output logic               push,
  output lcdw_pkg::lcdw_entry_t push_entry,
  input  logic               full
);
  import lcdw_pkg::*;

  logic [5:0] column;
  logic [5:0] column_next;
  logic [1:0] row;
  logic [1:0] row_next;
  logic       pend;      // row address command still to queue
  logic       pend_next;

  logic       accept;
  logic [1:0] op;
  logic [7:0] value;
  logic       drop_char;
  logic       wrap;
  logic [6:0] column_inc;
  logic [2:0] row_inc;

  assign op         = s_tdata[1:0];
  assign value      = s_tdata[9:2];
  assign s_tready   = !pend && !full;
  assign accept     = s_tvalid && s_tready;
  assign drop_char  = (value == CHAR_NUL) || (value == CHAR_CR) || (value == CHAR_LF);
  assign column_inc = {1'b0, column} + 7'd1;
  assign row_inc    = {1'b0, row} + 3'd1;
  assign wrap       = column_inc >= 7'(COLUMNS);

  always_comb begin
    column_next = column;
    row_next    = row;
    pend_next   = pend;
    push        = 1'b0;
    push_entry  = '{data: value, sel: 1'b0, last: 1'b1};
    if (pend) begin
      push       = !full;
      pend_next  = full;
      push_entry = '{data: ROW_ADDR[row], sel: 1'b0, last: 1'b1};
    end else if (accept) begin
      case (op_t'(op))
        OP_CHAR: begin
          if (!drop_char) begin
            push       = 1'b1;
            push_entry = '{data: value, sel: 1'b1, last: !wrap};
            if (wrap) begin
              column_next = '0;
              row_next    = (row_inc >= 3'(ROWS)) ? 2'd0 : row_inc[1:0];
              pend_next   = 1'b1;
            end else begin
              column_next = column_inc[5:0];
            end
          end
        end
        OP_CMD: begin
          push = 1'b1;
        end
        OP_HOME: begin
          push        = 1'b1;
          push_entry  = '{data: ROW_ADDR[0], sel: 1'b0, last: 1'b1};
          column_next = '0;
          row_next    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      pend   <= 1'b0;
    end else begin
      column <= column_next;
      row    <= row_next;
      pend   <= pend_next;
    end
  end

endmodule

[hw/rtl/lcdw_fifo.sv]
// Small queue of LCD bytes between front and back end.
module lcdw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lcdw_pkg::lcdw_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output lcdw_pkg::lcdw_entry_t head
);
  import lcdw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdw_entry_t    mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || $past(1'b0))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[hw/rtl/lcdw_back.sv]
// Back end: expands each queued LCD byte into six expander bus bytes.
module lcdw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  lcdw_pkg::lcdw_entry_t head,
  output logic                  pop,
  input  logic [7:0]            backlight_mask,
  input  logic [7:0]            enable_mask,
  input  logic [7:0]            select_mask,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] bus_byte
  output logic                  m_tlast
);
  import lcdw_pkg::*;

  lcdw_entry_t cur;
  logic        busy;
  logic [2:0]  step;
  logic        load;
  logic        finish;
  logic [7:0]  sel;
  logic [7:0]  nib;
  logic [7:0]  bus_byte;

  assign load   = busy && (!m_tvalid || m_tready);
  assign finish = load && (step == STEP_LAST);
  assign pop    = head_valid && (!busy || finish);
  assign sel    = cur.sel ? select_mask : 8'h00;

  always_comb begin
    if (step < STEP_LOW) begin
      nib = sel | (cur.data & NIBBLE_MASK);
    end else begin
      nib = sel | ({cur.data[3:0], 4'h0} & NIBBLE_MASK);
    end
    case (step)
      3'd0, 3'd3: bus_byte = nib | backlight_mask;
      3'd1, 3'd4: bus_byte = nib | enable_mask | backlight_mask;
      default:    bus_byte = (nib & ~enable_mask) | backlight_mask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      m_tdata <= bus_byte;
      m_tlast <= cur.last && (step == STEP_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        step <= '0;
      end else if (load) begin
        step <= step + 3'd1;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("step past last bus byte");
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0)
    else $error("step not cleared while idle");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy && step == '0)
    else $error("new entry did not start at first bus byte");

endmodule

[tb/char_lcd_nibble_bus_writer_checker.sv]
`timescale 1ns / 100ps
// Checker for the LCD nibble bus writer: predicts the expander byte stream and compares it.
module char_lcd_nibble_bus_writer_checker #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // [1:0] op, [9:2] value, [15:10] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [7:0] bus_byte
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import lcdw_pkg::*;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       last;
  } bus_word_t;

  bus_word_t  expected_bus_bytes[$];
  int         mismatch_count = 0;
  int         expected_count = 0;

  logic [7:0] backlight_pat = BACKLIGHT_RESET;
  logic [7:0] enable_pat    = ENABLE_RESET;
  logic [7:0] select_pat    = SELECT_RESET;
  logic [5:0] cursor_col    = '0;
  logic [1:0] cursor_row    = '0;

  assign errors  = mismatch_count;
  assign pending = expected_count;

  // level, strobe high, strobe low
  function automatic void push_nibble(input logic [7:0] nib, input logic final_word);
    bus_word_t w;
    w.last     = 1'b0;
    w.bus_byte = nib | backlight_pat;
    expected_bus_bytes.push_back(w);
    w.bus_byte = nib | enable_pat | backlight_pat;
    expected_bus_bytes.push_back(w);
    w.bus_byte = (nib & ~enable_pat) | backlight_pat;
    w.last     = final_word;
    expected_bus_bytes.push_back(w);
  endfunction

  function automatic void push_lcd_byte(input logic [7:0] b, input logic [7:0] sel,
                                        input logic final_byte);
    logic [7:0] low_nib;
    low_nib = b << 4;
    push_nibble(sel | (b & NIBBLE_MASK), 1'b0);
    push_nibble(sel | (low_nib & NIBBLE_MASK), final_byte);
  endfunction

  function automatic void predict_lcd_item(input logic [1:0] op_bits, input logic [7:0] value);
    logic [7:0] lcd_bytes [2];
    logic [7:0] lcd_sel [2];
    int         count;
    count = 0;
    case (op_t'(op_bits))
      OP_CHAR: begin
        if (value != CHAR_NUL && value != CHAR_CR && value != CHAR_LF) begin
          lcd_bytes[0] = value;
          lcd_sel[0]   = select_pat;
          count        = 1;
          if (int'(cursor_col) + 1 >= COLUMNS) begin
            cursor_col = '0;
            if (int'(cursor_row) + 1 >= ROWS) cursor_row = '0;
            else cursor_row = cursor_row + 2'd1;
            lcd_bytes[1] = ROW_ADDR[cursor_row];
            lcd_sel[1]   = '0;
            count        = 2;
          end else begin
            cursor_col = cursor_col + 6'd1;
          end
        end
      end
      OP_CMD: begin
        lcd_bytes[0] = value;
        lcd_sel[0]   = '0;
        count        = 1;
      end
      OP_HOME: begin
        lcd_bytes[0] = ROW_ADDR[0];
        lcd_sel[0]   = '0;
        count        = 1;
        cursor_col   = '0;
        cursor_row   = '0;
      end
      default: ;
    endcase
    for (int i = 0; i < count; i++) push_lcd_byte(lcd_bytes[i], lcd_sel[i], i == count - 1);
  endfunction

  always @(posedge clk) begin
    bus_word_t want;
    if (rst) begin
      backlight_pat = BACKLIGHT_RESET;
      enable_pat    = ENABLE_RESET;
      select_pat    = SELECT_RESET;
      cursor_col    = '0;
      cursor_row    = '0;
      expected_bus_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BACKLIGHT: backlight_pat = cfg_data;
          REG_ENABLE:    enable_pat    = cfg_data;
          REG_SELECT:    select_pat    = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_lcd_item(s_tdata[1:0], s_tdata[9:2]);
      if (m_tvalid && m_tready) begin
        if (expected_bus_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected bus byte, expected none, got %02h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_bus_bytes.pop_front();
          if (m_tdata !== want.bus_byte) begin
            mismatch_count++;
            $display("%0t: bus byte mismatch, expected %02h, got %02h",
                     $time, want.bus_byte, m_tdata);
          end
          if (m_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: last flag mismatch, expected %0b, got %0b",
                     $time, want.last, m_tlast);
          end
        end
      end
    end
    expected_count = expected_bus_bytes.size();
  end

endmodule

[tb/char_lcd_nibble_bus_writer_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the LCD nibble bus writer: stimulus, flow control and verdict.
module char_lcd_nibble_bus_writer_core_tb;
  import lcdw_pkg::*;

  localparam int ROWS            = 4;
  localparam int COLUMNS         = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // not decoded, block must ignore it
  localparam int CYCLE_LIMIT     = 200000;   // watchdog, far above the slowest legal run
  localparam int SETTLE_CYCLES   = 12;       // covers queue + byte reg + output reg
  localparam int HOLD_OFF_CYCLES = 300;      // long m_tready stall to back up the queue
  localparam int PHASE_ITEMS     = 27;       // items per random phase that make output

  localparam logic [1:0] MASK_REGS [3] = '{REG_BACKLIGHT, REG_ENABLE, REG_SELECT};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // [1:0] op, [9:2] value, [15:10] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // [7:0] bus_byte
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BACKLIGHT;
  logic [7:0]  cfg_data  = '0;

  // flow control knobs, set by the stimulus process between phases
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_request  = 1'b0;

  int          errors;
  int          pending;

  char_lcd_nibble_bus_writer_core #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  char_lcd_nibble_bus_writer_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) bus_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // 50 MHz
  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang or a lost bus byte ends here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side. Random m_tready per cycle; one long hold-off on request,
  // counted here, so the queue fills and s_tready has to drop.
  initial begin
    logic hold_done;
    int   held;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        held = 1;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Offer one item; valid stays high afterwards so back-to-back items
  // go out with no bubble unless the idle draw says otherwise.
  task automatic send_item(input logic [1:0] op, input logic [7:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, value, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly random characters so the cursor walks all rows and wraps;
  // some commands, a few homes, and noise the block has to drop.
  // made_output tells the caller whether the item produces bus bytes.
  task automatic send_random_item(input int home_pct, output bit made_output);
    int         pick;
    logic [7:0] v;
    pick        = $urandom_range(99, 0);
    v           = 8'($urandom_range(255, 0));
    made_output = 1'b1;
    if (pick < 78) begin
      send_item(OP_CHAR, v);
      made_output = !(v == CHAR_NUL || v == CHAR_CR || v == CHAR_LF);
    end else if (pick < 84) begin
      case ($urandom_range(2, 0))
        0:       v = CHAR_NUL;
        1:       v = CHAR_CR;
        default: v = CHAR_LF;
      endcase
      send_item(OP_CHAR, v);
      made_output = 1'b0;
    end else if (pick < 94) begin
      send_item(OP_CMD, v);
    end else if (pick < 94 + home_pct) begin
      send_item(OP_HOME, v);
    end else begin
      send_item(OP_UNUSED, v);
      made_output = 1'b0;
    end
  endtask

  // Wait for every predicted byte, then let any dropped item clear the pipe.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All three mask registers in one burst; cfg_valid held across the burst.
  task automatic program_masks(input logic [7:0] bl, input logic [7:0] en,
                               input logic [7:0] sel);
    logic [7:0] vals [3];
    vals = '{bl, en, sel};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= MASK_REGS[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int home_pct);
    int done;
    bit made_output;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      send_random_item(home_pct, made_output);
      if (made_output) done++;
    end
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset masks, no idling on either side.
    send_item(OP_HOME, 8'hFF);       // home: value ignored, cursor to row 0
    send_item(OP_CMD, 8'h00);        // raw command of zero is not dropped
    send_item(OP_CMD, 8'hFF);
    send_item(OP_CHAR, CHAR_NUL);    // dropped characters
    send_item(OP_UNUSED, 8'h00);     // unused op
    send_item(OP_CHAR, CHAR_CR);
    send_item(OP_CHAR, CHAR_LF);
    // every row: each full row wraps and brings the next row's address,
    // the last one wraps back to row 0
    for (int i = 0; i < ROWS * COLUMNS; i++) begin
      if (i == 0)      send_item(OP_CHAR, 8'hFF);
      else if (i == 1) send_item(OP_CHAR, 8'h01);
      else             send_item(OP_CHAR, 8'h40 + 8'(i));
    end
    s_tvalid <= 1'b0;
    wait_drained();

    // Sender idles a little, receiver a lot; masks at one extreme.
    // No homes here.
    program_masks(8'h00, 8'hFF, 8'h00);
    run_phase(14, 68, 0);

    // Other way round; masks at the opposite extreme.
    program_masks(8'hFF, 8'h00, 8'hFF);
    run_phase(68, 14, 2);

    // Full rate with random masks; starts with the long receiver hold-off.
    program_masks(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)));
    hold_request <= 1'b1;
    run_phase(0, 0, 2);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
